FILE: hw/rtl/gme_pkg.sv
// Shared types and constants for the grid MST edge acceptor.
`default_nettype none

package gme_pkg;

    localparam int NODE_W   = 12;
    localparam int WEIGHT_W = 8;
    localparam int COUNT_W  = 12;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Candidate edge item
    typedef struct packed {
        logic [NODE_W-1:0]   node_a;
        logic [NODE_W-1:0]   node_b;
        logic                is_vertical;
        logic [WEIGHT_W-1:0] weight;
    } t_edge;

    // Result item: edge echo when accepted, all zero when rejected
    typedef struct packed {
        logic                accepted;
        logic [NODE_W-1:0]   tree_node_a;
        logic [NODE_W-1:0]   tree_node_b;
        logic                tree_vertical;
        logic [WEIGHT_W-1:0] tree_weight;
    } t_result;

endpackage

`default_nettype wire

FILE: hw/rtl/gme_stream_if.sv
// Valid/ready stream channel carrying one payload item per handshake.
`default_nettype none

interface gme_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/gme_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module gme_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/grid_mst_edge_acceptor.sv
// Kruskal edge acceptor: union-find over a parent/count table in one RAM.
// Each accepted edge walks node_a, then node_b, to its root; distinct roots are then
// linked (child write, then root count write), and an out-of-range edge goes to the result.
// One item in work at a time: the next is taken the cycle after the result loads.
// Reset: a clearing pass writes every entry as its own
// root with zero count; no item is accepted until it ends.
`default_nettype none

module grid_mst_edge_acceptor
    import gme_pkg::*;
#(
    parameter int NODE_COUNT = 4096
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    gme_stream_if.sink   i_edge,
    gme_stream_if.source o_res
);

    localparam int IDX_W = $clog2(NODE_COUNT);
    localparam int ENT_W = COUNT_W + IDX_W;
    localparam logic [16:0] NodeLimit = 17'(NODE_COUNT);
    localparam logic [IDX_W-1:0] LastIdx = IDX_W'(NODE_COUNT - 1);

    typedef logic [IDX_W-1:0] t_idx;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        t_idx               parent;
    } t_entry;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FIND_A,
        S_FIND_B,
        S_LINK_CHILD,
        S_LINK_ROOT,
        S_RESULT
    } t_state;

    t_state             r_state, n_state;
    t_idx               r_clr, n_clr;
    t_idx               r_cur, n_cur;
    t_idx               r_root_a, n_root_a;
    logic [COUNT_W-1:0] r_cnt_a, n_cnt_a;
    t_idx               r_root, n_root;
    t_idx               r_child, n_child;
    logic [COUNT_W-1:0] r_root_cnt, n_root_cnt;
    logic [COUNT_W-1:0] r_child_cnt, n_child_cnt;
    t_edge              r_edge, n_edge;
    logic               r_ok, n_ok;
    t_result            r_out, n_out;
    logic               r_out_valid, n_out_valid;

    logic   wr_en;
    t_idx   wr_addr;
    t_entry wr_data;
    t_idx   rd_addr;
    t_entry rd_data;
    logic   rd_is_root;
    logic   a_ok, b_ok;

    gme_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NODE_COUNT)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign i_edge.ready = (r_state == S_IDLE);
    assign o_res.valid  = r_out_valid;
    assign o_res.data   = r_out;

    // Chain walk stops at a self-parented entry (or a stray out-of-range link)
    assign rd_is_root = (rd_data.parent == r_cur) || (17'(rd_data.parent) >= NodeLimit);
    assign a_ok       = 17'(i_edge.data.node_a) < NodeLimit;
    assign b_ok       = 17'(i_edge.data.node_b) < NodeLimit;

    // Table access
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_clr;
        wr_data = '{count: '0, parent: r_clr};
        rd_addr = r_cur;
        case (r_state)
            S_CLEAR: begin
                wr_en = 1'b1;
            end
            S_IDLE: begin
                rd_addr = t_idx'(i_edge.data.node_a);
            end
            S_FIND_A: begin
                rd_addr = rd_is_root ? t_idx'(r_edge.node_b) : rd_data.parent;
            end
            S_FIND_B: begin
                rd_addr = rd_data.parent;
            end
            S_LINK_CHILD: begin
                wr_en   = 1'b1;
                wr_addr = r_child;
                wr_data = '{count: r_child_cnt, parent: r_root};
            end
            S_LINK_ROOT: begin
                wr_en   = 1'b1;
                wr_addr = r_root;
                wr_data = '{count: (r_root_cnt == COUNT_MAX) ? r_root_cnt
                                                              : r_root_cnt + 1'b1,
                            parent: r_root};
            end
            default: begin
            end
        endcase
    end

    // Sequencer next state
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_cur       = r_cur;
        n_root_a    = r_root_a;
        n_cnt_a     = r_cnt_a;
        n_root      = r_root;
        n_child     = r_child;
        n_root_cnt  = r_root_cnt;
        n_child_cnt = r_child_cnt;
        n_edge      = r_edge;
        n_ok        = r_ok;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == LastIdx) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_edge.valid) begin
                    n_edge = i_edge.data;
                    n_cur  = t_idx'(i_edge.data.node_a);
                    n_ok   = 1'b0;
                    n_state = (a_ok && b_ok) ? S_FIND_A : S_RESULT;
                end
            end
            S_FIND_A: begin
                if (rd_is_root) begin
                    n_root_a = r_cur;
                    n_cnt_a  = rd_data.count;
                    n_cur    = t_idx'(r_edge.node_b);
                    n_state  = S_FIND_B;
                end else begin
                    n_cur = rd_data.parent;
                end
            end
            S_FIND_B: begin
                if (rd_is_root) begin
                    if (r_cur == r_root_a) begin
                        n_state = S_RESULT;
                    end else if (r_cnt_a >= rd_data.count) begin
                        n_root      = r_root_a;
                        n_root_cnt  = r_cnt_a;
                        n_child     = r_cur;
                        n_child_cnt = rd_data.count;
                        n_state     = S_LINK_CHILD;
                    end else begin
                        n_root      = r_cur;
                        n_root_cnt  = rd_data.count;
                        n_child     = r_root_a;
                        n_child_cnt = r_cnt_a;
                        n_state     = S_LINK_CHILD;
                    end
                end else begin
                    n_cur = rd_data.parent;
                end
            end
            S_LINK_CHILD: begin
                n_state = S_LINK_ROOT;
            end
            S_LINK_ROOT: begin
                n_ok    = 1'b1;
                n_state = S_RESULT;
            end
            S_RESULT: begin
                // Load the output register once it is free
                if (!r_out_valid || o_res.ready) begin
                    if (r_ok) begin
                        n_out = '{accepted:      1'b1,
                                  tree_node_a:   r_edge.node_a,
                                  tree_node_b:   r_edge.node_b,
                                  tree_vertical: r_edge.is_vertical,
                                  tree_weight:   r_edge.weight};
                    end else begin
                        n_out = '0;
                    end
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_ok        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            r_ok        <= n_ok;
        end
        r_cur       <= n_cur;
        r_root_a    <= n_root_a;
        r_cnt_a     <= n_cnt_a;
        r_root      <= n_root;
        r_child     <= n_child;
        r_root_cnt  <= n_root_cnt;
        r_child_cnt <= n_child_cnt;
        r_edge      <= n_edge;
        r_out       <= n_out;
    end

endmodule

`default_nettype wire
